@@ sv/hsrl_pkg.sv @@
// hsrl_pkg: shared types and constants for the heading/speed rate limiter.
// Used by hsrl_div and heading_speed_rate_limiter. No dependencies.
package hsrl_pkg;

  localparam int unsigned COURSE_FULL = 92160;
  localparam int unsigned COURSE_HALF = 46080;
  // 1 knot = 463/900 m/s; Q8.8 scaling folds in as 463/230400 = (463/1024)/225
  localparam int unsigned KNOT_NUM    = 463;
  // ceil(2^38/225) split in 16-bit halves; exact floor(y/225) for y < 2^30
  localparam int unsigned RECIP_HI    = 18641;
  localparam int unsigned RECIP_LO    = 23011;

  localparam int unsigned DIVD_W = 40;
  localparam int unsigned DIVS_W = 18;
  localparam int unsigned CNT_W  = 6;

  localparam logic [2:0] REG_UPDATE_DELAY   = 3'd0;
  localparam logic [2:0] REG_SNAP_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_ACCEL_RATE     = 3'd2;
  localparam logic [2:0] REG_BASE_TURN_RATE = 3'd3;
  localparam logic [2:0] REG_FULL_RATE_ZONE = 3'd4;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_TURN  = 12'b000000000010,
    S_MUL1  = 12'b000000000100,
    S_MUL2  = 12'b000000001000,
    S_REC1  = 12'b000000010000,
    S_REC2  = 12'b000000100000,
    S_MUL3  = 12'b000001000000,
    S_DIV   = 12'b000010000000,
    S_MUL4  = 12'b000100000000,
    S_APPLY = 12'b001000000000,
    S_SPEED = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

endpackage

@@ sv/heading_speed_rate_limiter.sv @@
// Heading and speed rate limiter: one shared multiplier and divider under a sequencer.
// Depends on hsrl_pkg and hsrl_div.
// A turn that computes a step runs the multiply steps and one divide on hsrl_div; when
// the turn timer holds or the course snaps, the sequencer goes straight to the speed step.
// in_tready is high only while idle, so one request is handled at a time, and a
// stalled result holds the sequencer until the output register frees.
// Synchronous active-low reset clears state, timers and output valid; config regs
// return to their defaults.
module heading_speed_rate_limiter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] delta_time, [31:16] target_speed, [48:32] target_course, zero pad
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [16:0] course_now, [32:17] speed_now, [33] moving, zero pad
  output logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_wdata
);
  import hsrl_pkg::*;

  logic [19:0] delay_r;
  logic [15:0] snap_r, accel_r, btr_r, zone_r;

  state_t state_r;
  logic [20:0] turn_tmr_r, speed_tmr_r;
  logic signed [15:0] speed_r;
  logic [16:0] course_r;

  logic [15:0] dt_r;
  logic signed [15:0] tspd_r;
  logic [16:0] tc_r;
  logic signed [18:0] err_r;
  logic [15:0] m_r;
  logic [32:0] prod_r;
  logic [29:0] rec_lo_r;
  logic [22:0] rate_r;
  logic [15:0] step_r;

  logic        out_valid_r;
  logic [16:0] out_course_r;
  logic [15:0] out_speed_r;

  // shared multiplier
  logic [32:0] mul_a;
  logic [15:0] mul_b;
  logic [48:0] mul_p;
  logic [44:0] rec_sum;

  div_req_t    dreq;
  logic        ddone;
  logic [DIVD_W-1:0] dquo;

  hsrl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dreq),
    .done     (ddone),
    .quotient (dquo)
  );

  logic [16:0] spd_mag;
  logic [15:0] zone_eff;
  logic [16:0] tc_in;
  logic [21:0] turn_sum, speed_sum;
  logic signed [18:0] err_raw, err_w;
  logic [16:0] aerr;
  logic [22:0] step_raw;
  logic signed [18:0] course_sum;
  logic        positive;
  logic signed [17:0] sdiff, sp_up, sp_dn;
  logic [17:0] sdiff_mag;

  assign spd_mag  = speed_r[15] ? 17'(-$signed({speed_r[15], speed_r})) : {1'b0, speed_r};
  assign zone_eff = (zone_r == 16'd0) ? 16'd1 : zone_r;
  assign tc_in    = (in_tdata[48:32] >= 17'(COURSE_FULL)) ?
                    17'(in_tdata[48:32] - 17'(COURSE_FULL)) : in_tdata[48:32];
  assign turn_sum  = {1'b0, turn_tmr_r} + {6'd0, dt_r};
  assign speed_sum = {1'b0, speed_tmr_r} + {6'd0, dt_r};

  always_comb begin
    err_raw = $signed({2'b00, tc_r}) - $signed({2'b00, course_r});
    err_w   = err_raw;
    if (err_raw > 19'sd46080) err_w = err_raw - 19'sd92160;
    if (err_raw < -19'sd46080) err_w = err_raw + 19'sd92160;
    aerr = err_w[18] ? 17'(-err_w) : err_w[16:0];
  end

  always_comb begin
    unique case (state_r)
      S_MUL1:  begin mul_a = {16'd0, spd_mag}; mul_b = btr_r; end
      S_MUL2:  begin mul_a = prod_r; mul_b = 16'(KNOT_NUM); end
      S_REC1:  begin mul_a = prod_r; mul_b = 16'(RECIP_LO); end
      S_REC2:  begin mul_a = prod_r; mul_b = 16'(RECIP_HI); end
      S_MUL3:  begin mul_a = {10'd0, rate_r}; mul_b = m_r; end
      S_MUL4:  begin mul_a = {10'd0, rate_r}; mul_b = dt_r; end
      S_SPEED: begin mul_a = {17'd0, accel_r}; mul_b = dt_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = mul_a * mul_b;
  end

  // y * ceil(2^38/225) from two 16-bit halves; upper half of the low product folds in
  assign rec_sum = mul_p[44:0] + {15'd0, rec_lo_r};

  always_comb begin
    dreq.start    = (state_r == S_MUL3);
    dreq.dividend = mul_p[DIVD_W-1:0];
    dreq.divisor  = {2'b00, zone_eff};
  end

  assign step_raw   = mul_p[38:16];
  assign positive   = (err_r > 0) == (speed_r >= 0);
  assign course_sum = positive ? $signed({2'b00, course_r}) + $signed({3'b000, step_r})
                               : $signed({2'b00, course_r}) - $signed({3'b000, step_r});
  assign sdiff      = 18'(tspd_r) - 18'(speed_r);
  assign sdiff_mag  = sdiff[17] ? 18'(-sdiff) : sdiff;
  assign sp_up      = 18'(speed_r) + $signed({2'b00, mul_p[31:16]});
  assign sp_dn      = 18'(speed_r) - $signed({2'b00, mul_p[31:16]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
      snap_r  <= 16'd256;
      accel_r <= 16'd256;
      btr_r   <= 16'd256;
      zone_r  <= 16'd7680;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UPDATE_DELAY:   delay_r <= cfg_wdata;
        REG_SNAP_THRESHOLD: snap_r  <= cfg_wdata[15:0];
        REG_ACCEL_RATE:     accel_r <= cfg_wdata[15:0];
        REG_BASE_TURN_RATE: btr_r   <= cfg_wdata[15:0];
        REG_FULL_RATE_ZONE: zone_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      turn_tmr_r  <= '0;
      speed_tmr_r <= '0;
      speed_r     <= '0;
      course_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            dt_r    <= in_tdata[15:0];
            tspd_r  <= in_tdata[31:16];
            tc_r    <= tc_in;
            state_r <= S_TURN;
          end
        end
        S_TURN: begin
          if (turn_sum < {2'b00, delay_r}) begin
            turn_tmr_r <= turn_sum[20:0];
            state_r    <= S_SPEED;
          end else begin
            turn_tmr_r <= '0;
            err_r      <= err_w;
            m_r        <= (aerr < {1'b0, zone_eff}) ? aerr[15:0] : zone_eff;
            if (aerr < {1'b0, snap_r}) begin
              course_r <= tc_r;
              state_r  <= S_SPEED;
            end else begin
              state_r <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          prod_r  <= mul_p[32:0];
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod_r  <= mul_p[42:10];  // times 463/1024, below 2^30
          state_r <= S_REC1;
        end
        S_REC1: begin
          rec_lo_r <= mul_p[45:16];
          state_r  <= S_REC2;
        end
        S_REC2: begin
          rate_r  <= rec_sum[44:22];
          state_r <= S_MUL3;
        end
        S_MUL3: state_r <= S_DIV;
        S_DIV: begin
          if (ddone) begin
            rate_r  <= dquo[22:0];  // reused to hold the zone-scaled rate
            state_r <= S_MUL4;
          end
        end
        S_MUL4: begin
          step_r  <= (step_raw > 23'(COURSE_HALF)) ? 16'(COURSE_HALF) : step_raw[15:0];
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (course_sum >= 19'sd92160) begin
            course_r <= 17'(course_sum - 19'sd92160);
          end else if (course_sum < 0) begin
            course_r <= 17'(course_sum + 19'sd92160);
          end else begin
            course_r <= course_sum[16:0];
          end
          state_r <= S_SPEED;
        end
        S_SPEED: begin
          if (speed_sum < {2'b00, delay_r}) begin
            speed_tmr_r <= speed_sum[20:0];
          end else begin
            speed_tmr_r <= '0;
            if (sdiff_mag < {2'b00, snap_r}) begin
              speed_r <= tspd_r;
            end else if (sdiff > 0) begin
              speed_r <= (sp_up > 18'(tspd_r)) ? tspd_r : sp_up[15:0];
            end else begin
              speed_r <= (sp_dn < 18'(tspd_r)) ? tspd_r : sp_dn[15:0];
            end
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_course_r <= course_r;
            out_speed_r  <= speed_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, (out_speed_r != 16'd0), out_speed_r, out_course_r};

endmodule

@@ sv/hsrl_div.sv @@
// hsrl_div: restoring divider, one quotient bit per cycle.
// Depends on hsrl_pkg.
module hsrl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hsrl_pkg::div_req_t            req,
  output logic                          done,
  output logic [hsrl_pkg::DIVD_W-1:0]   quotient
);
  import hsrl_pkg::*;

  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [DIVS_W:0]   trial;
  logic              qbit;

  always_comb begin
    trial = {rem_r, quo_r[DIVD_W-1]};
    qbit  = (trial >= {1'b0, dvs_r});
    if (qbit) begin
      rem_nxt = DIVS_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[DIVS_W-1:0];
    end
    quo_nxt = {quo_r[DIVD_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ sv/hsrl_checker.sv @@
// hsrl_checker: port-level assertions for heading_speed_rate_limiter, with bind.
// Depends on heading_speed_rate_limiter ports only.
module hsrl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[33] == (out_tdata[32:17] != 16'd0)))
    else $error("moving flag disagrees with speed");

  a_course_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[16:0] < 17'd92160))
    else $error("course out of range");

  // one request at a time: no back-to-back accept
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a request while busy");

endmodule

bind heading_speed_rate_limiter hsrl_checker u_hsrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/heading_speed_rate_limiter_tb.sv @@
`timescale 1ns / 1ps
// Testbench for heading_speed_rate_limiter: directed and random ticks under several
// register settings and idle patterns, checked against an in-bench course/speed predictor.
// Depends on hsrl_pkg and the block's RTL.
module heading_speed_rate_limiter_tb;
  import hsrl_pkg::*;

  // unmapped register index, writes must be ignored
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic        moving;
    logic [15:0] speed;
    logic [16:0] course;
  } nav_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_wdata = '0;

  heading_speed_rate_limiter u_top (.*);

  always #4 clk = ~clk;

  // predictor state and register copies
  longint delay_r, snap_r, accel_r, turn_rate_r, zone_r;
  longint spd_tmr, crs_tmr, speed_st, course_st;

  logic [55:0] tick_q[$];
  nav_t        nav_q[$];
  int          errors = 0;
  int          send_idle = 0, recv_stall = 0;
  int          hold_cycles = 0;
  int          quiet = 0;
  int          accepted = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, accepted);
    errors++;
  endtask

  function automatic nav_t advance_nav(input logic [55:0] d);
    longint dt, tspd, tcrs, err, aerr, zone, m, rate, step, diff;
    nav_t r;
    dt = d[15:0];
    tspd = $signed(d[31:16]);
    tcrs = d[48:32];
    if (tcrs >= COURSE_FULL) tcrs -= COURSE_FULL;
    crs_tmr += dt;
    if (crs_tmr >= delay_r) begin
      crs_tmr = 0;
      err = tcrs - course_st;
      if (err > longint'(COURSE_HALF)) err -= COURSE_FULL;
      if (err < -longint'(COURSE_HALF)) err += COURSE_FULL;
      aerr = err < 0 ? -err : err;
      if (aerr < snap_r) course_st = tcrs;
      else begin
        zone = zone_r == 0 ? 1 : zone_r;
        m = aerr < zone ? aerr : zone;
        rate = (turn_rate_r * (speed_st < 0 ? -speed_st : speed_st) * 463) / 230400;
        step = ((rate * m) / zone * dt) >> 16;
        if (step > COURSE_HALF) step = COURSE_HALF;
        if ((err > 0) != (speed_st >= 0)) step = -step;
        course_st += step;
        if (course_st >= longint'(COURSE_FULL)) course_st -= COURSE_FULL;
        if (course_st < 0) course_st += COURSE_FULL;
      end
    end
    spd_tmr += dt;
    if (spd_tmr >= delay_r) begin
      spd_tmr = 0;
      diff = tspd - speed_st;
      if ((diff < 0 ? -diff : diff) < snap_r) speed_st = tspd;
      else begin
        step = (accel_r * dt) >> 16;
        if (diff > 0) begin
          speed_st += step;
          if (speed_st > tspd) speed_st = tspd;
        end else begin
          speed_st -= step;
          if (speed_st < tspd) speed_st = tspd;
        end
      end
    end
    r.course = course_st[16:0];
    r.speed = speed_st[15:0];
    r.moving = speed_st != 0;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      nav_q.push_back(advance_nav(in_tdata));
      void'(tick_q.pop_front());
    end
    if (tick_q.size() > (in_tvalid && in_tready ? 0 : 1) || (!(in_tvalid && in_tready)
        && tick_q.size() > 0)) begin
      if (in_tvalid && !in_tready) in_tvalid <= 1'b1;
      else if ($urandom_range(99) < send_idle) in_tvalid <= 1'b0;
      else begin
        in_tvalid <= 1'b1;
        in_tdata <= (in_tvalid && in_tready) ? tick_q[0] : tick_q[0];
      end
    end else in_tvalid <= 1'b0;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else out_tready <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  // monitor and watchdog
  always @(posedge clk) begin
    nav_t got, want;
    if (out_tvalid && out_tready) begin
      got = out_tdata[33:0];
      accepted++;
      if (nav_q.size() == 0) begin
        $display("unexpected result %0d", accepted);
        errors++;
      end else begin
        want = nav_q.pop_front();
        if (got.course !== want.course) report("course_now", got.course, want.course);
        if (got.speed !== want.speed)
          report("speed_now", $signed(got.speed), $signed(want.speed));
        if (got.moving !== want.moving) report("moving", got.moving, want.moving);
        if (out_tdata[39:34] !== '0) report("pad", out_tdata[39:34], 0);
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic set_reg(input logic [2:0] idx, input longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[19:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_UPDATE_DELAY:   delay_r = val[19:0];
      REG_SNAP_THRESHOLD: snap_r = val[15:0];
      REG_ACCEL_RATE:     accel_r = val[15:0];
      REG_BASE_TURN_RATE: turn_rate_r = val[15:0];
      REG_FULL_RATE_ZONE: zone_r = val[15:0];
      default: ;
    endcase
  endtask

  task automatic push_tick(input longint dt, input longint spd, input longint crs);
    logic [55:0] d;
    d = '0;
    d[15:0] = dt[15:0];
    d[31:16] = spd[15:0];
    d[48:32] = crs[16:0];
    tick_q.push_back(d);
  endtask

  function automatic longint rand_speed();
    return longint'($urandom_range(32768)) - 16384;
  endfunction

  task automatic drain();
    wait (tick_q.size() == 0 && !in_tvalid);
    wait (nav_q.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic random_ticks(input int n, input int dtmax);
    repeat (n) begin
      if ($urandom_range(9) == 0)
        push_tick($urandom_range(65535), rand_speed(), $urandom_range(131071));
      else
        push_tick($urandom_range(dtmax), rand_speed(), $urandom_range(92159));
    end
  endtask

  initial begin
    delay_r = 0; snap_r = 256; accel_r = 256; turn_rate_r = 256; zone_r = 7680;
    spd_tmr = 0; crs_tmr = 0; speed_st = 0; course_st = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, wrap, exact half turn, out-of-range course, reverse speed
    push_tick(0, 0, 0);
    push_tick(65535, 16384, 46080);
    push_tick(65535, 16384, 92159);
    push_tick(65535, -16384, 131071);
    push_tick(65535, -16384, 92160);
    push_tick(32768, 16384, 1000);
    push_tick(65535, 0, 47080);
    push_tick(65535, 16384, 0);
    push_tick(65535, 16384, 0);
    drain();
    set_reg(REG_SNAP_THRESHOLD, 0);
    set_reg(REG_FULL_RATE_ZONE, 0);
    set_reg(REG_BASE_TURN_RATE, 65535);
    set_reg(REG_ACCEL_RATE, 65535);
    set_reg(REG_UNMAPPED, 12345);
    push_tick(65535, 16384, 30000);
    push_tick(65535, 16384, 30000);
    push_tick(65535, 16384, 76080);
    push_tick(65535, -16384, 5);
    push_tick(1, -16384, 5);
    drain();
    set_reg(REG_ACCEL_RATE, 0);
    set_reg(REG_FULL_RATE_ZONE, 46080);
    set_reg(REG_UPDATE_DELAY, 1048575);
    push_tick(65535, 100, 200);
    push_tick(65535, -200, 300);
    drain();
    set_reg(REG_UPDATE_DELAY, 100000);
    push_tick(65535, 100, 200);
    push_tick(65535, -16384, 300);
    push_tick(65535, 16384, 92159);
    drain();
    // random phases across settings and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      set_reg(REG_UPDATE_DELAY, ph % 3 == 0 ? 0 : $urandom_range(ph == 7 ? 1048575 : 70000));
      set_reg(REG_SNAP_THRESHOLD, ph == 1 ? 65535 : $urandom_range(ph % 2 ? 0 : 1024));
      set_reg(REG_ACCEL_RATE, ph == 2 ? 65535 : $urandom_range(8192));
      set_reg(REG_BASE_TURN_RATE, ph == 3 ? 0 : $urandom_range(65535));
      set_reg(REG_FULL_RATE_ZONE, ph == 4 ? 1 : $urandom_range(1, 46080));
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 73; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 73; end
        default: begin send_idle = 13; recv_stall = 13; end
      endcase
      if (ph == 0) hold_cycles = 2000;
      random_ticks(175, ph % 2 ? 65535 : 8000);
      drain();
    end
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
